// ===== sv/grid_snap_with_occupancy_macros.svh =====
// Assertion helpers for the grid snap block.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef GRID_SNAP_WITH_OCCUPANCY_MACROS_SVH
`define GRID_SNAP_WITH_OCCUPANCY_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GSO_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GSO_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define GSO_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define GSO_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/gso_pkg.sv =====
package gso_pkg;

   localparam int COORD_W    = 16;
   localparam int BOARD_W    = 6;
   localparam int WIDTH_W    = 12;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int MAP_ROW_W  = 5;
   localparam int MAP_BIT_W  = 5;
   localparam int CELL_IDX_W = MAP_ROW_W + MAP_BIT_W;
   localparam int MAP_ROWS   = 1 << MAP_ROW_W;
   localparam int MAP_WORD_W = 1 << MAP_BIT_W;
   // fixed-point positions and distances: 16*31*4094 and 65535*31 fit in 22 bits
   localparam int POS_W      = 22;
   localparam int FB_STEP_W  = WIDTH_W + 4;

   localparam logic [BOARD_W-1:0] FB_MIN_LINES      = 6'd2;
   localparam logic [BOARD_W-1:0] FB_MAX_LINES      = 6'd32;
   localparam logic [BOARD_W-1:0] BOARD_SIZE_RESET  = 6'd19;
   localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET = 12'd800;

   typedef enum logic [1:0] {
      OP_FRAME  = 2'd0,
      OP_ADD_X  = 2'd1,
      OP_ADD_Y  = 2'd2,
      OP_DETECT = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOARD_SIZE  = 1'b0,
      CSR_IMAGE_WIDTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic init;
      logic step;
   } scan_ctl_type;

endpackage

// ===== sv/gso_ram.sv =====
module gso_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/gso_axis.sv =====
module gso_axis #(
   parameter int SEL_W = 5
) (
   input  logic                       clock,
   input  gso_pkg::scan_ctl_type      ctl,
   input  logic [SEL_W-1:0]           cand_idx,
   input  logic [gso_pkg::POS_W-1:0]  cand_pos,
   input  logic [gso_pkg::POS_W-1:0]  target,
   output logic [SEL_W-1:0]           best_idx
);

   import gso_pkg::*;

   logic [POS_W:0]     best_d_ff;
   logic [SEL_W-1:0]   best_idx_ff;
   logic [POS_W-1:0]   abs_gap;

   assign abs_gap = (cand_pos > target) ? (cand_pos - target) : (target - cand_pos);

   // strict less-than: earlier index keeps a tie
   always_ff @(posedge clock) begin
      if (ctl.init) begin
         best_d_ff   <= '1;
         best_idx_ff <= '0;
      end else if (ctl.step && ({1'b0, abs_gap} < best_d_ff)) begin
         best_d_ff   <= {1'b0, abs_gap};
         best_idx_ff <= cand_idx;
      end
   end

   assign best_idx = best_idx_ff;

endmodule

// ===== sv/grid_snap_with_occupancy.sv =====
// Grid snap with occupancy. Line loads (op 1 and 2) write the next free entry
// of the x or y line RAM; loads into a full table are dropped. A frame start
// (op 0) empties both tables and sweeps the 32-row occupancy RAM to zero one
// row per cycle, and the block is busy while it sweeps; the same sweep runs
// after reset before req_ready first rises. A detection (op 3) scans N
// entries, where N is max(x lines, y lines) when both tables hold lines and
// the saturated board_size (2..32) otherwise: a scan pointer walks the line
// RAMs (or the evenly spaced fallback positions) one entry per cycle, with one
// distance/compare unit per axis, then a multiply forms the cell number and a
// read-modify-write of the occupancy row tests and marks the cell. A detection
// whose cell is taken or lies beyond 1023 gives no result. One result register
// holds the outgoing transfer; a new detection stalls only if that register is
// still full when its own result is ready. CSR writes take effect at once and
// are expected only while the block is idle.
`include "grid_snap_with_occupancy_macros.svh"

module grid_snap_with_occupancy #(
   parameter int MAX_LINES = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_op,
   input  logic [gso_pkg::COORD_W-1:0]        req_coord_x,
   input  logic [gso_pkg::COORD_W-1:0]        req_coord_y,
   input  logic                               req_is_black,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [gso_pkg::CELL_IDX_W-1:0]     rsp_cell_index,
   output logic                               rsp_cell_black,
   // CSR write port
   input  logic                               csr_wr_en,
   input  logic [gso_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gso_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import gso_pkg::*;

   localparam int IDX_W  = $clog2(MAX_LINES);
   localparam int CNT_W  = $clog2(MAX_LINES + 1);
   // scan length / column count must also hold the fallback count (up to 32)
   localparam int LEN_W  = (CNT_W > BOARD_W) ? CNT_W : BOARD_W;
   localparam int SEL_W  = (IDX_W > 5) ? IDX_W : 5;
   localparam int CELL_W = SEL_W + LEN_W + 1;
   localparam logic [CNT_W-1:0] LINES_FULL = CNT_W'(MAX_LINES);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_CELL,
      ST_MAPRD,
      ST_MAPCHK,
      ST_EMIT
   } state_type;

   state_type               state_ff;
   logic [MAP_ROW_W-1:0]    clr_row_ff;

   logic [BOARD_W-1:0]      board_size_ff;
   logic [WIDTH_W-1:0]      image_width_ff;
   logic [CNT_W-1:0]        x_count_ff;
   logic [CNT_W-1:0]        y_count_ff;

   // detection context
   logic [COORD_W-1:0]      cx_ff;
   logic [COORD_W-1:0]      cy_ff;
   logic                    blk_ff;
   logic                    fallback_ff;
   logic [FB_STEP_W-1:0]    step_ff;
   logic [POS_W-1:0]        tgt_x_ff;
   logic [POS_W-1:0]        tgt_y_ff;
   logic [LEN_W-1:0]        scan_len_ff;
   logic [LEN_W-1:0]        xcount_ff;

   // scan pointer and delay registers that line up with RAM read data
   logic [LEN_W-1:0]        issue_ff;
   logic [POS_W-1:0]        pos_acc_ff;
   logic                    d_vld_ff;
   logic [SEL_W-1:0]        d_idx_ff;
   logic [POS_W-1:0]        d_pos_ff;

   logic [CELL_W-1:0]       cell_ff;
   logic [CELL_W-1:0]       cell_in;

   logic                    rsp_valid_ff;
   logic [CELL_IDX_W-1:0]   rsp_cell_index_ff;
   logic                    rsp_cell_black_ff;

   // combinational
   op_type                  op_sel;
   logic                    req_xfer;
   logic                    mode_fb;
   logic [BOARD_W-1:0]      b_sat;
   logic [BOARD_W-1:0]      b_m1;
   logic [WIDTH_W-1:0]      w_m1;
   logic [LEN_W-1:0]        max_count;
   logic [POS_W-1:0]        fb_tgt_x;
   logic [POS_W-1:0]        fb_tgt_y;

   logic                    xram_we;
   logic                    yram_we;
   logic [COORD_W-1:0]      xram_rd;
   logic [COORD_W-1:0]      yram_rd;
   logic [IDX_W-1:0]        ram_rd_addr;

   logic                    map_we;
   logic [MAP_ROW_W-1:0]    map_wr_addr;
   logic [MAP_WORD_W-1:0]   map_wr_data;
   logic [MAP_WORD_W-1:0]   map_rd;
   logic [MAP_BIT_W-1:0]    map_bit;
   logic                    map_hit;

   scan_ctl_type            ctl_x;
   scan_ctl_type            ctl_y;
   logic [POS_W-1:0]        cand_x;
   logic [POS_W-1:0]        cand_y;
   logic [SEL_W-1:0]        col_idx;
   logic [SEL_W-1:0]        row_idx;

   assign op_sel    = op_type'(req_op);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   // ---------------------------------------------------------------------
   // Fallback grid setup: saturate board size, spacing numerator is
   // 16*(W-1) per line, detection target is c*(B-1).
   // ---------------------------------------------------------------------
   always_comb begin
      priority if (board_size_ff < FB_MIN_LINES) begin
         b_sat = FB_MIN_LINES;
      end else if (board_size_ff > FB_MAX_LINES) begin
         b_sat = FB_MAX_LINES;
      end else begin
         b_sat = board_size_ff;
      end
   end

   assign b_m1     = b_sat - BOARD_W'(1);
   assign w_m1     = (image_width_ff == '0) ? '0 : (image_width_ff - WIDTH_W'(1));
   assign fb_tgt_x = POS_W'(cx_ff) * POS_W'(b_m1);
   assign fb_tgt_y = POS_W'(cy_ff) * POS_W'(b_m1);
   assign mode_fb  = (x_count_ff == '0) || (y_count_ff == '0);
   assign max_count = (x_count_ff > y_count_ff) ? LEN_W'(x_count_ff) : LEN_W'(y_count_ff);

   // ---------------------------------------------------------------------
   // Line tables
   // ---------------------------------------------------------------------
   assign xram_we     = req_xfer && (op_sel == OP_ADD_X) && (x_count_ff < LINES_FULL);
   assign yram_we     = req_xfer && (op_sel == OP_ADD_Y) && (y_count_ff < LINES_FULL);
   assign ram_rd_addr = issue_ff[IDX_W-1:0];

   gso_ram #(.WIDTH(COORD_W), .DEPTH(MAX_LINES)) u_xram (
      .clock   (clock),
      .wr_en   (xram_we),
      .wr_addr (x_count_ff[IDX_W-1:0]),
      .wr_data (req_coord_x),
      .rd_addr (ram_rd_addr),
      .rd_data (xram_rd)
   );

   gso_ram #(.WIDTH(COORD_W), .DEPTH(MAX_LINES)) u_yram (
      .clock   (clock),
      .wr_en   (yram_we),
      .wr_addr (y_count_ff[IDX_W-1:0]),
      .wr_data (req_coord_y),
      .rd_addr (ram_rd_addr),
      .rd_data (yram_rd)
   );

   // ---------------------------------------------------------------------
   // Nearest-line units, one per axis. Entries past an axis' own count
   // are masked when the two tables differ in length.
   // ---------------------------------------------------------------------
   assign ctl_x.init = (state_ff == ST_SETUP);
   assign ctl_y.init = (state_ff == ST_SETUP);
   assign ctl_x.step = (state_ff == ST_SCAN) && d_vld_ff &&
                       (fallback_ff || (LEN_W'(d_idx_ff) < LEN_W'(x_count_ff)));
   assign ctl_y.step = (state_ff == ST_SCAN) && d_vld_ff &&
                       (fallback_ff || (LEN_W'(d_idx_ff) < LEN_W'(y_count_ff)));
   assign cand_x     = fallback_ff ? d_pos_ff : POS_W'(xram_rd);
   assign cand_y     = fallback_ff ? d_pos_ff : POS_W'(yram_rd);

   gso_axis #(.SEL_W(SEL_W)) u_axis_x (
      .clock    (clock),
      .ctl      (ctl_x),
      .cand_idx (d_idx_ff),
      .cand_pos (cand_x),
      .target   (tgt_x_ff),
      .best_idx (col_idx)
   );

   gso_axis #(.SEL_W(SEL_W)) u_axis_y (
      .clock    (clock),
      .ctl      (ctl_y),
      .cand_idx (d_idx_ff),
      .cand_pos (cand_y),
      .target   (tgt_y_ff),
      .best_idx (row_idx)
   );

   assign cell_in = CELL_W'(row_idx) * CELL_W'(xcount_ff) + CELL_W'(col_idx);

   // ---------------------------------------------------------------------
   // Occupancy map: 32 rows of 32 bits, cell[9:5] picks the row.
   // Clear sweep and the mark write share the single write port.
   // ---------------------------------------------------------------------
   assign map_bit = cell_ff[MAP_BIT_W-1:0];
   assign map_hit = map_rd[map_bit];

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         map_we      = 1'b1;
         map_wr_addr = clr_row_ff;
         map_wr_data = '0;
      end else begin
         map_we      = (state_ff == ST_MAPCHK) && !map_hit;
         map_wr_addr = cell_ff[CELL_IDX_W-1:MAP_BIT_W];
         map_wr_data = map_rd | (MAP_WORD_W'(1) << map_bit);
      end
   end

   gso_ram #(.WIDTH(MAP_WORD_W), .DEPTH(MAP_ROWS)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (cell_ff[CELL_IDX_W-1:MAP_BIT_W]),
      .rd_data (map_rd)
   );

   // ---------------------------------------------------------------------
   // Sequencer, CSRs and result register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_row_ff     <= '0;
         board_size_ff  <= BOARD_SIZE_RESET;
         image_width_ff <= IMAGE_WIDTH_RESET;
         x_count_ff     <= '0;
         y_count_ff     <= '0;
         d_vld_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_BOARD_SIZE:  board_size_ff  <= csr_wdata[BOARD_W-1:0];
               CSR_IMAGE_WIDTH: image_width_ff <= csr_wdata[WIDTH_W-1:0];
            endcase
         end

         // in EMIT the reload below takes over the drained register
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               clr_row_ff <= clr_row_ff + MAP_ROW_W'(1);
               if (clr_row_ff == MAP_ROW_W'(MAP_ROWS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_xfer) begin
                  cx_ff  <= req_coord_x;
                  cy_ff  <= req_coord_y;
                  blk_ff <= req_is_black;
                  unique case (op_sel)
                     OP_FRAME: begin
                        x_count_ff <= '0;
                        y_count_ff <= '0;
                        clr_row_ff <= '0;
                        state_ff   <= ST_CLEAR;
                     end
                     OP_ADD_X: begin
                        if (xram_we) begin
                           x_count_ff <= x_count_ff + CNT_W'(1);
                        end
                     end
                     OP_ADD_Y: begin
                        if (yram_we) begin
                           y_count_ff <= y_count_ff + CNT_W'(1);
                        end
                     end
                     OP_DETECT: begin
                        state_ff <= ST_SETUP;
                     end
                  endcase
               end
            end
            ST_SETUP: begin
               fallback_ff <= mode_fb;
               step_ff     <= {w_m1, 4'b0000};
               tgt_x_ff    <= mode_fb ? fb_tgt_x : POS_W'(cx_ff);
               tgt_y_ff    <= mode_fb ? fb_tgt_y : POS_W'(cy_ff);
               scan_len_ff <= mode_fb ? LEN_W'(b_sat) : max_count;
               xcount_ff   <= mode_fb ? LEN_W'(b_sat) : LEN_W'(x_count_ff);
               issue_ff    <= '0;
               pos_acc_ff  <= '0;
               d_vld_ff    <= 1'b0;
               state_ff    <= ST_SCAN;
            end
            ST_SCAN: begin
               if (issue_ff != scan_len_ff) begin
                  d_vld_ff   <= 1'b1;
                  d_idx_ff   <= SEL_W'(issue_ff);
                  d_pos_ff   <= pos_acc_ff;
                  issue_ff   <= issue_ff + LEN_W'(1);
                  pos_acc_ff <= pos_acc_ff + POS_W'(step_ff);
               end else begin
                  // last compare happens while d_vld_ff is still high
                  d_vld_ff <= 1'b0;
                  if (!d_vld_ff) begin
                     state_ff <= ST_CELL;
                  end
               end
            end
            ST_CELL: begin
               cell_ff  <= cell_in;
               state_ff <= ST_MAPRD;
            end
            ST_MAPRD: begin
               // cells past the map are dropped unmarked
               if (|cell_ff[CELL_W-1:CELL_IDX_W]) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_MAPCHK;
               end
            end
            ST_MAPCHK: begin
               state_ff <= map_hit ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_cell_index_ff <= cell_ff[CELL_IDX_W-1:0];
                  rsp_cell_black_ff <= blk_ff;
                  state_ff          <= ST_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_index = rsp_cell_index_ff;
   assign rsp_cell_black = rsp_cell_black_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `GSO_ASSERT_NXT(a_full_x_holds, clock, reset, req_xfer && (op_sel == OP_ADD_X) && (x_count_ff == LINES_FULL), x_count_ff == LINES_FULL, "x line load into full table changed the count")
   `GSO_ASSERT_NXT(a_frame_clears, clock, reset, req_xfer && (op_sel == OP_FRAME), (state_ff == ST_CLEAR) && (x_count_ff == '0) && (y_count_ff == '0), "frame start did not empty tables and start clear")
   `GSO_ASSERT_IMP(a_pick_in_grid, clock, reset, state_ff == ST_CELL, (LEN_W'(col_idx) < xcount_ff) && (LEN_W'(row_idx) < (fallback_ff ? xcount_ff : LEN_W'(y_count_ff))), "nearest line index outside the grid")
   `GSO_ASSERT_NXT(a_emit_loads, clock, reset, (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (rsp_cell_index_ff == $past(cell_ff[CELL_IDX_W-1:0])), "result register not loaded with the cell")

endmodule

// ===== tb/grid_snap_with_occupancy_tb.sv =====
module grid_snap_with_occupancy_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gso_pkg::*;

   // Stimulus volume and timing knobs
   localparam int LINE_SLOTS   = 32;     // line table depth in the block
   localparam int MAP_CELLS    = 1024;
   localparam int ITEM_TARGET  = 1500;   // last phase runs over: about 1600 items in all
   localparam int PHASE_ITEMS  = 110;    // items between CSR updates
   localparam int DRAIN_CYCLES = 50;     // covers the worst busy time of a frame or a detect
   localparam int HOLD_CYCLES  = 300;    // long receiver hold-off

   typedef struct packed {
      op_type      op;
      logic [15:0] x;
      logic [15:0] y;
      logic        black;
   } grid_req_type;

   typedef struct packed {
      logic [9:0] cell_idx;
      logic       black;
   } placement_type;

   // DUT-facing signals; those the bench drives are known from time zero
   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   op_type      req_op       = OP_FRAME;
   logic [15:0] req_coord_x  = '0;
   logic [15:0] req_coord_y  = '0;
   logic        req_is_black = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b0;
   logic [9:0]  rsp_cell_index;
   logic        rsp_cell_black;
   logic        csr_wr_en    = 1'b0;
   csr_index_type csr_index  = CSR_BOARD_SIZE;
   logic [11:0] csr_wdata    = '0;

   // Items waiting to be offered, and placements waiting to come out
   grid_req_type  req_backlog [$];
   placement_type placement_due [$];
   grid_req_type  offered;
   placement_type due;
   int            queued_items = 0;
   int            fault_count  = 0;

   // Pacing controls shared by the stimulus thread, driver and monitor
   bit calm       = 1'b0;    // pick_gap gives no idle gap while set; a long hold still applies
   int send_gap   = 0;
   int stall_left = 0;
   int hold_left  = 0;
   int hold_asked = 0;
   int hold_taken = 0;

   // Shadow of the block: line tables, counts, occupancy and CSRs
   logic [15:0] x_lines [LINE_SLOTS];
   logic [15:0] y_lines [LINE_SLOTS];
   int          x_count   = 0;
   int          y_count   = 0;
   bit [MAP_CELLS-1:0] taken = '0;
   logic [5:0]  board_reg = BOARD_SIZE_RESET;
   logic [11:0] width_reg = IMAGE_WIDTH_RESET;

   grid_snap_with_occupancy dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_is_black   (req_is_black),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_index (rsp_cell_index),
      .rsp_cell_black (rsp_cell_black),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   // Nearest loaded line on one axis; strict compare keeps the lowest index on a tie
   function automatic int nearest_line(input bit on_y, input logic [15:0] c);
      int best = 0;
      int n;
      int unsigned best_d = 32'hFFFF_FFFF;
      int unsigned v, d;
      n = on_y ? y_count : x_count;
      for (int i = 0; i < n; i++) begin
         v = on_y ? y_lines[i] : x_lines[i];
         d = (v > c) ? v - c : c - v;
         if (d < best_d) begin
            best_d = d;
            best = i;
         end
      end
      return best;
   endfunction

   // Evenly spaced grid: compare 16*i*(w-1) against c*(b-1), no division
   function automatic int snap_even(input int unsigned b, input int unsigned w,
                                    input logic [15:0] c);
      int best = 0;
      longint unsigned best_d = 64'hFFFF_FFFF_FFFF_FFFF;
      longint unsigned target, spot, d;
      target = longint'(c) * longint'(b - 1);
      for (int unsigned i = 0; i < b; i++) begin
         spot = 64'd16 * longint'(i) * longint'(w - 1);
         d = (spot > target) ? spot - target : target - spot;
         if (d < best_d) begin
            best_d = d;
            best = int'(i);
         end
      end
      return best;
   endfunction

   // Advance the shadow state by one accepted transfer, queue any placement
   function automatic void apply_item(input grid_req_type item);
      int b, w, col, row, cols, slot;
      case (item.op)
         OP_FRAME: begin
            x_count = 0;
            y_count = 0;
            taken = '0;
         end
         OP_ADD_X: begin
            if (x_count < LINE_SLOTS) begin
               x_lines[x_count] = item.x;
               x_count++;
            end
         end
         OP_ADD_Y: begin
            if (y_count < LINE_SLOTS) begin
               y_lines[y_count] = item.y;
               y_count++;
            end
         end
         default: begin
            if (x_count == 0 || y_count == 0) begin
               // fallback grid, board size saturated, width 0 read as 1
               b = (board_reg < FB_MIN_LINES) ? 2 : ((board_reg > FB_MAX_LINES) ? 32 : board_reg);
               w = (width_reg == 0) ? 1 : width_reg;
               col = snap_even(b, w, item.x);
               row = snap_even(b, w, item.y);
               cols = b;
            end else begin
               col = nearest_line(1'b0, item.x);
               row = nearest_line(1'b1, item.y);
               cols = x_count;
            end
            slot = row * cols + col;
            if (slot < MAP_CELLS && !taken[slot]) begin
               taken[slot] = 1'b1;
               placement_due.insert(placement_due.size(),
                                    placement_type'{cell_idx: 10'(slot), black: item.black});
            end
         end
      endcase
   endfunction

   task automatic report_fault(input string what, input logic [31:0] want,
                               input logic [31:0] got);
      fault_count++;
      if (fault_count <= 10)
         $display("mismatch on %s: expected %0d, got %0d", what, want, got);
   endtask

   function automatic void push_req(input op_type op, input logic [15:0] x,
                                    input logic [15:0] y, input logic black);
      req_backlog.insert(req_backlog.size(), grid_req_type'{op: op, x: x, y: y, black: black});
      queued_items++;
   endfunction

   // Request driver: predicts on each transfer, then offers the next item
   // after a random gap. Valid holds with a stable payload until taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            apply_item(offered);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               offered = req_backlog.pop_front();
               req_valid    <= 1'b1;
               req_op       <= offered.op;
               req_coord_x  <= offered.x;
               req_coord_y  <= offered.y;
               req_is_black <= offered.black;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each transfer against the oldest placement,
   // and paces rsp_ready with random stalls plus the occasional long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (placement_due.size() == 0) begin
               report_fault("unexpected result, cell", 32'd0, 32'(rsp_cell_index));
            end else begin
               due = placement_due.pop_front();
               if (rsp_cell_index !== due.cell_idx)
                  report_fault("cell_index", 32'(due.cell_idx), 32'(rsp_cell_index));
               if (rsp_cell_black !== due.black)
                  report_fault("cell_black", 32'(due.black), 32'(rsp_cell_black));
            end
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (hold_taken != hold_asked) begin
            hold_taken = hold_taken + 1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
               stall_left = pick_gap();
         end
      end
   end

   // Block is idle: nothing to send, nothing owed, then let any
   // no-result item finish before touching the CSRs.
   task automatic wait_quiet();
      @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || placement_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [11:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_BOARD_SIZE)
         board_reg = data[5:0];
      else
         width_reg = data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int pick_count();
      int r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 12);
      if (r < 90) return $urandom_range(13, 32);
      return $urandom_range(33, 40);   // overflows the table
   endfunction

   // One frame: clear, load lines (sometimes none on an axis, sometimes too
   // many), then detections aimed near lines, at midpoints, repeated, or
   // anywhere, with a sprinkle of stray items.
   task automatic gen_frame();
      logic [15:0] lines [2][40];
      logic [15:0] pos [2];
      logic [15:0] last [2];
      int          cnt [2];
      int          ndet, step, base, t, k, j, n;
      bit          have_last;
      bit          fallback;
      have_last = 1'b0;
      push_req(OP_FRAME, 16'($urandom), 16'($urandom), 1'($urandom));
      cnt[0] = pick_count();
      cnt[1] = pick_count();
      t = $urandom_range(0, 99);
      if (t < 15) begin
         cnt[0] = 0;
         cnt[1] = 0;
      end else if (t < 22) begin
         cnt[0] = 0;
      end else if (t < 29) begin
         cnt[1] = 0;
      end
      for (int a = 0; a < 2; a++) begin
         step = $urandom_range(16, 2048);
         base = $urandom_range(0, 8192);
         for (int i = 0; i < cnt[a]; i++) begin
            t = $urandom_range(0, 19);
            if (t == 0)
               lines[a][i] = 16'($urandom);
            else if (t == 1 && i > 0)
               lines[a][i] = lines[a][i-1];   // duplicate line: tie on index
            else
               lines[a][i] = 16'(base + i * step + int'($urandom_range(0, step / 4)));
            if (a == 0)
               push_req(OP_ADD_X, lines[a][i], 16'($urandom), 1'($urandom));
            else
               push_req(OP_ADD_Y, 16'($urandom), lines[a][i], 1'($urandom));
         end
      end
      fallback = (cnt[0] == 0 || cnt[1] == 0);
      ndet = $urandom_range(4, 40);
      for (int d = 0; d < ndet; d++) begin
         for (int a = 0; a < 2; a++) begin
            n = (cnt[a] > LINE_SLOTS) ? LINE_SLOTS : cnt[a];
            t = $urandom_range(0, 99);
            if (t >= 88) begin
               pos[a] = 16'($urandom);
            end else if (fallback) begin
               pos[a] = 16'($urandom_range(0, width_reg * 16 + 64));
            end else if (t < 70) begin
               k = $urandom_range(0, n - 1);
               j = int'(lines[a][k]) + int'($urandom_range(0, 128)) - 64;
               pos[a] = (j < 0) ? 16'd0 : ((j > 65535) ? 16'hFFFF : 16'(j));
            end else begin
               // midpoint of two lines: exact ties when the sum is even
               k = $urandom_range(0, n - 1);
               j = $urandom_range(0, n - 1);
               pos[a] = 16'((int'(lines[a][k]) + int'(lines[a][j])) / 2);
            end
         end
         if (have_last && $urandom_range(0, 9) == 0)
            pos = last;                       // same spot again: occupied unless a stray item came between
         push_req(OP_DETECT, pos[0], pos[1], 1'($urandom));
         last = pos;
         have_last = 1'b1;
         if ($urandom_range(0, 24) == 0)
            push_req(op_type'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                     1'($urandom));
      end
   endtask

   // Stimulus sequence and verdict
   initial begin
      int         phase;
      int         quota;
      int         r;
      logic [5:0] bs;
      logic [5:0] junk;
      logic [11:0] iw;
      phase = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset CSRs (19 lines over 800 px)
      push_req(OP_DETECT, 16'd0, 16'd0, 1'b1);            // fallback, cell 0
      push_req(OP_DETECT, 16'd0, 16'd0, 1'b0);            // already taken
      push_req(OP_DETECT, 16'hFFFF, 16'hFFFF, 1'b1);      // far corner
      push_req(OP_FRAME, 16'hFFFF, 16'hFFFF, 1'b1);       // clear
      push_req(OP_DETECT, 16'd0, 16'd0, 1'b0);            // free again
      push_req(OP_ADD_X, 16'd1600, 16'hFFFF, 1'b1);
      push_req(OP_ADD_X, 16'd4800, 16'd0, 1'b0);
      push_req(OP_DETECT, 16'd4800, 16'd4800, 1'b1);      // y table empty: fallback
      push_req(OP_ADD_Y, 16'hFFFF, 16'd1600, 1'b0);
      push_req(OP_ADD_Y, 16'd0, 16'd3200, 1'b1);
      push_req(OP_DETECT, 16'd3200, 16'd2400, 1'b1);      // ties both axes -> cell 0, taken
      push_req(OP_DETECT, 16'd4800, 16'd3200, 1'b0);
      push_req(OP_DETECT, 16'hFFFF, 16'd0, 1'b1);
      push_req(OP_ADD_X, 16'd0, 16'd0, 1'b0);             // column count grows mid-frame
      push_req(OP_DETECT, 16'd0, 16'd3200, 1'b0);
      push_req(OP_ADD_Y, 16'd0, 16'd1600, 1'b0);          // duplicate y line
      push_req(OP_DETECT, 16'd1600, 16'd1600, 1'b1);
      push_req(OP_DETECT, 16'd0, 16'd1600, 1'b1);
      push_req(OP_ADD_X, 16'hFFFF, 16'hFFFF, 1'b1);
      push_req(OP_DETECT, 16'hFFFF, 16'hFFFF, 1'b1);
      push_req(OP_FRAME, 16'd0, 16'd0, 1'b0);
      push_req(OP_DETECT, 16'd0, 16'd0, 1'b0);
      wait_quiet();

      // Full tables: loads past 32 entries are dropped
      push_req(OP_FRAME, 16'd0, 16'd0, 1'b0);
      for (int i = 0; i < 34; i++) begin
         push_req(OP_ADD_X, 16'(i * 1984), 16'($urandom), 1'($urandom));
         push_req(OP_ADD_Y, 16'($urandom), 16'(i * 1984), 1'($urandom));
      end
      push_req(OP_DETECT, 16'hFFFF, 16'hFFFF, 1'b1);      // cell 1023
      push_req(OP_DETECT, 16'd0, 16'd0, 1'b0);
      push_req(OP_DETECT, 16'd992, 16'd992, 1'b1);        // midway tie
      wait_quiet();

      // Random phases, each under its own CSR setting; extremes first
      while (queued_items < ITEM_TARGET) begin
         case (phase)
            0: begin bs = 6'd2;  iw = 12'd2;    end
            1: begin bs = 6'd0;  iw = 12'd0;    end
            2: begin bs = 6'd63; iw = 12'd4095; end
            3: begin bs = 6'd1;  iw = 12'd4095; end
            4: begin bs = 6'd32; iw = 12'd2;    end
            5: begin bs = 6'd33; iw = 12'd1;    end
            default: begin
               r = $urandom_range(0, 99);
               bs = (r < 80) ? 6'($urandom_range(2, 32)) : 6'($urandom);
               r = $urandom_range(0, 99);
               iw = (r < 30) ? 12'($urandom_range(2, 64)) : 12'($urandom);
            end
         endcase
         // upper data bits beyond the 6-bit board size are ignored
         junk = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'd0;
         write_csr(CSR_BOARD_SIZE, {junk, bs});
         write_csr(CSR_IMAGE_WIDTH, iw);
         @(negedge clock);
         calm = (phase % 3 == 1);
         if (phase == 1 || $urandom_range(0, 4) == 0) begin
            // receiver holds off while items keep coming: block backs up
            calm = 1'b1;
            hold_asked = hold_asked + 1;
         end
         push_req(OP_FRAME, 16'd0, 16'd0, 1'b0);
         push_req(OP_DETECT, 16'd0, 16'd0, 1'b1);
         push_req(OP_DETECT, 16'hFFFF, 16'hFFFF, 1'b0);
         push_req(OP_DETECT, 16'd8, 16'd8, 1'b1);
         quota = queued_items + PHASE_ITEMS;
         while (queued_items < quota)
            gen_frame();
         // sender pauses here until every placement has come back
         wait_quiet();
         phase++;
      end

      wait_quiet();
      if (fault_count == 0 && placement_due.size() == 0)
         $display("PASS grid_snap_with_occupancy");
      else
         $display("FAIL grid_snap_with_occupancy");
      $finish;
   end

   // Watchdog, well beyond the slowest legal run
   initial begin
      #15_000_000;
      $display("FAIL grid_snap_with_occupancy");
      $finish;
   end

endmodule

// ===== grid_snap_with_occupancy.f =====
+incdir+sv
sv/gso_pkg.sv
sv/gso_ram.sv
sv/gso_axis.sv
sv/grid_snap_with_occupancy.sv
tb/grid_snap_with_occupancy_tb.sv
